// ----- sv/krt_pkg.sv -----
package krt_pkg;

    // default sizing of the table
    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int KEY_BITS_DEF      = 32;

    // field widths of requests and responses
    localparam int OP_W   = 2;
    localparam int KEY_W  = 32;
    localparam int AMT_W  = 16;
    localparam int ST_W   = 3;
    localparam int SLOT_W = 6;
    localparam int CNT_W  = 32;
    localparam int RET_W  = 16;

    typedef logic [OP_W-1:0] t_op;
    typedef logic [ST_W-1:0] t_status;

    // operation codes
    localparam t_op OP_ACQUIRE = 2'd0;
    localparam t_op OP_USE     = 2'd1;
    localparam t_op OP_ADD     = 2'd2;
    localparam t_op OP_LOOKUP  = 2'd3;

    // status codes
    localparam t_status ST_FOUND     = 3'd0;
    localparam t_status ST_CREATED   = 3'd1;
    localparam t_status ST_FREED     = 3'd2;
    localparam t_status ST_MISSING   = 3'd3;
    localparam t_status ST_FULL      = 3'd4;
    localparam t_status ST_UNDERFLOW = 3'd5;

    typedef struct packed {
        t_op              operation;
        logic [KEY_W-1:0] key;
        logic [AMT_W-1:0] amount;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  use_count;
        logic [CNT_W-1:0]  use_limit;
        logic [RET_W-1:0]  retain_count;
    } t_rsp;

endpackage

// ----- sv/krt_if.sv -----
// request channel
interface krt_req_if import krt_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// response channel
interface krt_rsp_if import krt_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- sv/krt_ram.sv -----
module krt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/keyed_refcount_table.sv -----
// Keyed table of reference-counted entries held in one single-port-write,
// registered-read RAM (valid bit, key, use count, use limit, retain count per
// slot). After reset the block clears the valid bit of every slot and does not
// take requests meanwhile. Each request is then handled by a sequencer that
// scans the RAM one slot per cycle with a single key comparator, stopping at
// the first matching key, or running over every slot when the key is absent;
// the scan also notes the lowest empty slot. One response is produced per
// request; the response register lets the next request be taken while a
// finished response still waits.
module keyed_refcount_table import krt_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int KEY_BITS      = KEY_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    krt_req_if.sink       i_req,
    krt_rsp_if.source     o_rsp
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CTR_W  = IDX_W + 1;
    localparam int WORD_W = 1 + KEY_BITS + 2 * CNT_W + RET_W;
    localparam logic [CTR_W-1:0] NUM_ENT  = CTR_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    // control registers
    logic [2:0]       r_state, n_state;
    logic [CTR_W-1:0] r_cnt, n_cnt;
    logic             r_pend, n_pend;
    logic             r_out_valid, n_out_valid;

    // datapath registers
    logic [IDX_W-1:0]    r_pidx, n_pidx;
    t_op                 r_op, n_op;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [AMT_W-1:0]    r_amt, n_amt;
    logic                r_hit, n_hit;
    logic                r_free_hit, n_free_hit;
    logic [IDX_W-1:0]    r_free_idx, n_free_idx;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [CNT_W-1:0]    r_uc, n_uc;
    logic [CNT_W-1:0]    r_ul, n_ul;
    logic [RET_W-1:0]    r_rc, n_rc;
    t_status             r_st, n_st;
    logic                r_wr, n_wr;
    logic                r_chk, n_chk;
    t_rsp                r_out, n_out;

    // ram port signals
    logic              w_we, w_re;
    logic [IDX_W-1:0]  w_waddr, w_raddr;
    logic [WORD_W-1:0] w_wdata, w_rdata;

    logic                w_rd_valid;
    logic [KEY_BITS-1:0] w_rd_key;
    logic [CNT_W-1:0]    w_rd_uc, w_rd_ul;
    logic [RET_W-1:0]    w_rd_rc;

    logic [63:0]         w_key_ext;
    logic [KEY_BITS-1:0] w_key;
    logic [31:0]         w_idx_ext;
    logic                w_freed;
    logic                w_out_free;

    krt_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // entry word layout: valid, key, use count, use limit, retain count
    assign w_rd_valid = w_rdata[WORD_W-1];
    assign w_rd_key   = w_rdata[WORD_W-2 -: KEY_BITS];
    assign w_rd_uc    = w_rdata[2*CNT_W+RET_W-1 -: CNT_W];
    assign w_rd_ul    = w_rdata[CNT_W+RET_W-1 -: CNT_W];
    assign w_rd_rc    = w_rdata[RET_W-1:0];

    // key trimmed or zero-extended to the stored width
    assign w_key_ext = {32'd0, i_req.data.key};
    assign w_key     = w_key_ext[KEY_BITS-1:0];
    assign w_idx_ext = 32'(r_idx);

    // entry is released when use count meets limit with no retains left
    assign w_freed    = r_chk && (r_uc == r_ul) && (r_rc == '0);
    assign w_out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // sequencer and entry update
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_pidx      = r_pidx;
        n_op        = r_op;
        n_key       = r_key;
        n_amt       = r_amt;
        n_hit       = r_hit;
        n_free_hit  = r_free_hit;
        n_free_idx  = r_free_idx;
        n_idx       = r_idx;
        n_uc        = r_uc;
        n_ul        = r_ul;
        n_rc        = r_rc;
        n_st        = r_st;
        n_wr        = r_wr;
        n_chk       = r_chk;
        n_out       = r_out;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_waddr     = r_idx;
        w_raddr     = r_cnt[IDX_W-1:0];
        w_wdata     = {!w_freed, r_key, r_uc, r_ul, r_rc};

        unique case (r_state)
            S_CLR: begin
                // clear valid bits after reset
                w_we    = 1'b1;
                w_waddr = r_cnt[IDX_W-1:0];
                w_wdata = '0;
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt[IDX_W-1:0] == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op       = i_req.data.operation;
                    n_key      = w_key;
                    n_amt      = i_req.data.amount;
                    n_cnt      = '0;
                    n_pend     = 1'b0;
                    n_hit      = 1'b0;
                    n_free_hit = 1'b0;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                // issue next read while checking the previous one
                if (r_cnt != NUM_ENT) begin
                    w_re   = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_pend = 1'b1;
                    n_pidx = r_cnt[IDX_W-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    if (w_rd_valid && (w_rd_key == r_key)) begin
                        n_hit   = 1'b1;
                        n_idx   = r_pidx;
                        n_uc    = w_rd_uc;
                        n_ul    = w_rd_ul;
                        n_rc    = w_rd_rc;
                        n_state = S_EXEC;
                    end else if (!w_rd_valid && !r_free_hit) begin
                        n_free_hit = 1'b1;
                        n_free_idx = r_pidx;
                    end
                end else if (r_cnt == NUM_ENT) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_wr    = 1'b0;
                n_chk   = 1'b0;
                n_st    = ST_FOUND;
                n_state = S_DONE;
                priority if (!r_hit && (r_op != OP_ACQUIRE)) begin
                    n_st  = ST_MISSING;
                    n_idx = '0;
                    n_uc  = '0;
                    n_ul  = '0;
                    n_rc  = '0;
                end else begin
                    unique case (r_op)
                        OP_ACQUIRE: begin
                            if (r_hit) begin
                                n_rc = r_rc + 1'b1;
                                n_wr = 1'b1;
                            end else if (r_free_hit) begin
                                n_idx = r_free_idx;
                                n_uc  = '0;
                                n_ul  = '0;
                                n_rc  = RET_W'(1);
                                n_st  = ST_CREATED;
                                n_wr  = 1'b1;
                            end else begin
                                n_st  = ST_FULL;
                                n_idx = '0;
                                n_uc  = '0;
                                n_ul  = '0;
                                n_rc  = '0;
                            end
                        end
                        OP_USE: begin
                            n_uc  = r_uc + 1'b1;
                            n_wr  = 1'b1;
                            n_chk = 1'b1;
                        end
                        OP_ADD: begin
                            if (r_rc == '0) begin
                                n_st = ST_UNDERFLOW;
                            end else begin
                                n_ul  = r_ul + CNT_W'(r_amt);
                                n_rc  = r_rc - 1'b1;
                                n_wr  = 1'b1;
                                n_chk = 1'b1;
                            end
                        end
                        OP_LOOKUP: begin
                            n_st = ST_FOUND;
                        end
                        default: begin
                            n_st = ST_FOUND;
                        end
                    endcase
                end
            end
            S_DONE: begin
                // write back and hand over the response
                if (w_out_free) begin
                    w_we               = r_wr;
                    n_out_valid        = 1'b1;
                    n_out.status       = w_freed ? ST_FREED : r_st;
                    n_out.slot         = w_idx_ext[SLOT_W-1:0];
                    n_out.use_count    = r_uc;
                    n_out.use_limit    = r_ul;
                    n_out.retain_count = r_rc;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_pidx     <= n_pidx;
        r_op       <= n_op;
        r_key      <= n_key;
        r_amt      <= n_amt;
        r_hit      <= n_hit;
        r_free_hit <= n_free_hit;
        r_free_idx <= n_free_idx;
        r_idx      <= n_idx;
        r_uc       <= n_uc;
        r_ul       <= n_ul;
        r_rc       <= n_rc;
        r_st       <= n_st;
        r_wr       <= n_wr;
        r_chk      <= n_chk;
        r_out      <= n_out;
    end

endmodule
